>>> hdl/hmac_pkg.sv
// Shared types, constants and helper functions for the HMAC-SHA1 engine.
// No dependencies; hmac_queue, hmac_sha1_core, hmac_sha1_engine and the bench import this package.
package hmac_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int BLOCK_BITS = BLOCK_BYTES * 8;
	localparam int DIGEST_BYTES = 20;
	localparam int FILL_W = $clog2(BLOCK_BYTES);
	localparam int ROUNDS = 80;

	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5C;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [FILL_W-1:0] LEN_POS = FILL_W'(BLOCK_BYTES - 8);
	localparam logic [FILL_W-1:0] LAST_POS = FILL_W'(BLOCK_BYTES - 1);
	localparam logic [63:0] OUTER_LEN_BITS = 64'((BLOCK_BYTES + DIGEST_BYTES) * 8);

	localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
		32'h10325476, 32'hC3D2E1F0};

	// One input word as it waits in the queue.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} item_t;

	// Command from the sequencer to the compression unit.
	typedef struct packed {
		logic                  start;
		logic                  init;
		logic [BLOCK_BITS-1:0] block;
	} core_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_PADZ,
		ST_LEN,
		ST_OKEY,
		ST_DIG,
		ST_OUT
	} seq_state_t;

	function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
		rol32 = (x << n) | (x >> (32 - n));
	endfunction

endpackage

>>> hdl/hmac_if.sv
// Valid/ready channel interfaces for message input and digest output.
// Depends on nothing.
interface hmac_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;
	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface hmac_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_high;
	logic [63:0] digest_mid;
	logic [31:0] digest_low;
	modport source (output valid, digest_high, digest_mid, digest_low, input ready);
	modport sink (input valid, digest_high, digest_mid, digest_low, output ready);
endinterface

>>> hdl/hmac_queue.sv
// Front end: accepts input words into a two-entry queue for the sequencer.
// Depends on hmac_pkg and hmac_in_if.
module hmac_queue (
	input  logic           clk,
	input  logic           arst_n,
	hmac_in_if.sink        in_ch,
	input  logic           pop,
	output logic           item_valid,
	output hmac_pkg::item_t item
);
	import hmac_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       take;

	assign in_ch.ready = (count_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign item_valid = (count_q != 2'd0);
	assign take = pop && item_valid;
	assign item = slot_q[rd_ptr_q];

	// Pointer and occupancy bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (take) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, take};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{data_byte: in_ch.data_byte,
				byte_present: in_ch.byte_present, end_of_message: in_ch.end_of_message};
		end
	end
endmodule

>>> hdl/hmac_sha1_core.sv
// SHA-1 compression unit: one round per cycle, then a final step folds the result into the chain.
// Depends on hmac_pkg.
module hmac_sha1_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hmac_pkg::core_cmd_t  cmd,
	output logic                 busy,
	output logic [159:0]         chain
);
	import hmac_pkg::*;

	logic [31:0] chain_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];
	logic [6:0]  round_q;
	logic        busy_q;
	logic [31:0] f, k, t, w_new;

	assign busy = busy_q;
	assign chain = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};

	// Round function and schedule expansion.
	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		t = rol32(a_q, 5) + f + e_q + k + w_q[0];
		w_new = rol32(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			round_q <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			round_q <= '0;
		end else if (busy_q) begin
			if (round_q == 7'(ROUNDS)) busy_q <= 1'b0;
			round_q <= round_q + 7'd1;
		end
	end

	// Working variables, schedule window and chaining value.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 16; i++) w_q[i] <= cmd.block[BLOCK_BITS-1-32*i -: 32];
			for (int i = 0; i < 5; i++) begin
				if (cmd.init) chain_q[i] <= SHA1_IV[159-32*i -: 32];
			end
			a_q <= cmd.init ? SHA1_IV[159:128] : chain_q[0];
			b_q <= cmd.init ? SHA1_IV[127:96] : chain_q[1];
			c_q <= cmd.init ? SHA1_IV[95:64] : chain_q[2];
			d_q <= cmd.init ? SHA1_IV[63:32] : chain_q[3];
			e_q <= cmd.init ? SHA1_IV[31:0] : chain_q[4];
		end else if (busy_q) begin
			if (round_q == 7'(ROUNDS)) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end else begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
				e_q <= d_q;
				d_q <= c_q;
				c_q <= rol32(b_q, 30);
				b_q <= a_q;
				a_q <= t;
			end
		end
	end
endmodule

>>> hdl/hmac_sha1_engine.sv
// HMAC-SHA1 engine. Message bytes arrive one per input word on in_ch; the key sits in eight
// 64-bit registers written through cfg_we/cfg_index/cfg_data (index 0 holds key bytes 0..7,
// big-endian, zero past the key length; keys above 64 bytes must be hashed by software). A
// word with end_of_message set yields one 160-bit HMAC on out_ch. A two-entry queue decouples
// the input from the sequencer. Every 64th byte starts a compression during which the next
// byte waits. The first word of a message waits while the inner key block is compressed, and
// the end adds padding plus the outer key block and outer digest.
// Depends on hmac_pkg, hmac_if, hmac_queue and hmac_sha1_core.
module hmac_sha1_engine (
	input  logic        clk,
	input  logic        arst_n,
	hmac_in_if.sink     in_ch,
	hmac_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import hmac_pkg::*;

	logic [63:0]           key_q [8];
	logic                  item_valid;
	item_t                 item;
	logic                  pop;
	core_cmd_t             cmd;
	logic                  core_busy;
	logic [159:0]          chain;
	seq_state_t            state_q, state_d;
	logic [BLOCK_BITS-1:0] buf_q;
	logic [FILL_W-1:0]     fill_q;
	logic [60:0]           msg_q;
	logic [60:0]           msg_next;
	logic                  started_q;
	logic                  outer_q;
	logic [63:0]           len_q;
	logic [159:0]          dig_q;
	logic [4:0]            cnt_q;
	logic                  out_valid_q;
	logic [159:0]          out_q;
	logic                  out_free;
	logic                  push_en;
	logic [7:0]            push_byte;
	logic                  key_start;
	logic [7:0]            key_pad;
	logic [BLOCK_BITS-1:0] key_block;
	logic [BLOCK_BITS-1:0] buf_next;

	hmac_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .pop(pop),
		.item_valid(item_valid), .item(item)
	);

	hmac_sha1_core u_core (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .busy(core_busy), .chain(chain)
	);

	// Key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) key_q[i] <= '0;
		end else if (cfg_we && cfg_index < 4'd8) begin
			key_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	assign out_free = !out_valid_q || out_ch.ready;
	assign msg_next = msg_q + {60'd0, item.byte_present};
	assign buf_next = {buf_q[BLOCK_BITS-9:0], push_byte};

	// Padded key block.
	always_comb begin
		for (int i = 0; i < 8; i++) key_block[BLOCK_BITS-1-64*i -: 64] = key_q[i] ^ {8{key_pad}};
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (!core_busy && item_valid && started_q && item.end_of_message)
				state_d = ST_PAD80;
			ST_PAD80: if (!core_busy) state_d = ST_PADZ;
			ST_PADZ: if (!core_busy && fill_q == LEN_POS) state_d = ST_LEN;
			ST_LEN: if (!core_busy && cnt_q == 5'd7) state_d = outer_q ? ST_OUT : ST_OKEY;
			ST_OKEY: if (!core_busy) state_d = ST_DIG;
			ST_DIG: if (!core_busy && cnt_q == 5'(DIGEST_BYTES - 1)) state_d = ST_PAD80;
			ST_OUT: if (!core_busy && out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer actions.
	always_comb begin
		pop = 1'b0;
		push_en = 1'b0;
		push_byte = item.data_byte;
		key_start = 1'b0;
		key_pad = IPAD_BYTE;
		unique case (state_q)
			ST_IDLE: if (!core_busy && item_valid) begin
				if (!started_q) key_start = 1'b1;
				else begin
					pop = 1'b1;
					push_en = item.byte_present;
				end
			end
			ST_PAD80: begin
				push_en = !core_busy;
				push_byte = PAD_MARK;
			end
			ST_PADZ: begin
				push_en = !core_busy && fill_q != LEN_POS;
				push_byte = 8'h00;
			end
			ST_LEN: begin
				push_en = !core_busy;
				push_byte = len_q[63:56];
			end
			ST_OKEY: begin
				key_start = !core_busy;
				key_pad = OPAD_BYTE;
			end
			ST_DIG: begin
				push_en = !core_busy;
				push_byte = dig_q[159:152];
			end
			ST_OUT: ;
			default: ;
		endcase
		cmd.start = key_start || (push_en && fill_q == LAST_POS);
		cmd.init = key_start;
		cmd.block = key_start ? key_block : buf_next;
	end

	// Sequencer control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			msg_q <= '0;
			started_q <= 1'b0;
			outer_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (key_start) fill_q <= '0;
			else if (push_en) fill_q <= fill_q + 1'b1;
			if (key_start && !outer_q) begin
				msg_q <= '0;
				started_q <= 1'b1;
			end else if (pop) begin
				msg_q <= msg_next;
			end
			if (state_q == ST_PADZ) cnt_q <= '0;
			else if (state_q == ST_OKEY) cnt_q <= '0;
			else if (push_en && (state_q == ST_LEN || state_q == ST_DIG)) cnt_q <= cnt_q + 5'd1;
			if (state_q == ST_OKEY && !core_busy) outer_q <= 1'b1;
			if (state_q == ST_OUT && !core_busy && out_free) begin
				outer_q <= 1'b0;
				started_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sequencer data registers.
	always_ff @(posedge clk) begin
		if (push_en) buf_q <= buf_next;
		if (pop && item.end_of_message) len_q <= {61'(msg_next + 61'(BLOCK_BYTES)), 3'b000};
		else if (state_q == ST_DIG && state_d == ST_PAD80) len_q <= OUTER_LEN_BITS;
		else if (state_q == ST_LEN && push_en) len_q <= {len_q[55:0], 8'h00};
		if (state_q == ST_OKEY && !core_busy) dig_q <= chain;
		else if (state_q == ST_DIG && push_en) dig_q <= {dig_q[151:0], 8'h00};
		if (state_q == ST_OUT && !core_busy && out_free) out_q <= chain;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.digest_high = out_q[159:96];
	assign out_ch.digest_mid = out_q[95:32];
	assign out_ch.digest_low = out_q[31:0];

	// The compression unit is never restarted while it works.
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !core_busy) else $error("compression started while busy");

	// A digest appears only from the output state.
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT) else $error("stray digest");

	// Input is consumed only while the sequencer is idle and a message is open.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE && started_q)) else $error("item taken out of turn");
endmodule

>>> bench/tb_top.sv
// Self-checking bench for hmac_sha1_engine: streams message bytes, predicts each HMAC-SHA1.
// Depends on hmac_pkg, hmac_if and hmac_sha1_engine from the RTL tree.
`timescale 1ns / 1ps

module tb_top;
	import hmac_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int TAIL_CYCLES = 500;

	typedef struct packed {
		logic [63:0] high;
		logic [63:0] mid;
		logic [31:0] low;
	} mac_t;

	typedef struct {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
		logic       check_known;
		mac_t       known_mac;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [3:0] cfg_index;
	logic [63:0] cfg_data;

	hmac_in_if in_ch ();
	hmac_out_if out_ch ();

	hmac_sha1_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: key copy, chaining value, partial block and counters.
	logic [63:0] key_regs [8];
	logic [31:0] chain [5];
	logic [7:0] blk_buf [64];
	int unsigned blk_fill;
	logic [60:0] msg_count;
	bit msg_open;

	mac_t mac_queue [$];
	int errors;
	int macs_seen;
	int words_sent;
	longint cycles;
	int send_idle_pct;
	int recv_stall_pct;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// One SHA-1 compression of the given 64 bytes into the chaining value.
	task automatic sha1_block(input logic [7:0] b [64]);
		logic [31:0] w [80];
		logic [31:0] a, bb, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain[0]; bb = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (bb & c) | (~bb & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = bb ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (bb & c) | (bb & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = bb ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rotl(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rotl(bb, 30); bb = a; a = t;
		end
		chain[0] += a; chain[1] += bb; chain[2] += c; chain[3] += d; chain[4] += e;
	endtask

	task automatic key_pad_block(input logic [7:0] pad);
		logic [7:0] b [64];
		for (int i = 0; i < 64; i++)
			b[i] = key_regs[i/8][63 - 8*(i%8) -: 8] ^ pad;
		for (int i = 0; i < 5; i++)
			chain[i] = SHA1_IV[159 - 32*i -: 32];
		sha1_block(b);
	endtask

	task automatic add_byte(input logic [7:0] v);
		blk_buf[blk_fill] = v;
		blk_fill++;
		if (blk_fill == 64) begin
			sha1_block(blk_buf);
			blk_fill = 0;
		end
	endtask

	// Padding and the 64-bit bit length; the byte count wraps as in the block.
	task automatic pad_and_length(input logic [63:0] total);
		logic [63:0] bits;
		bits = total << 3;
		add_byte(PAD_MARK);
		while (blk_fill != 56)
			add_byte(8'h00);
		for (int i = 0; i < 8; i++)
			add_byte(bits[63 - 8*i -: 8]);
	endtask

	// Advances the predictor by one accepted word; pushes a MAC on an end mark.
	task automatic predict_word(input logic [7:0] v, input logic present, input logic last);
		logic [7:0] inner [20];
		if (!msg_open) begin
			key_pad_block(IPAD_BYTE);
			blk_fill = 0;
			msg_count = '0;
			msg_open = 1;
		end
		if (present) begin
			add_byte(v);
			msg_count = msg_count + 1;
		end
		if (last) begin
			pad_and_length({3'b000, 61'(msg_count + 61'd64)});
			for (int i = 0; i < 20; i++)
				inner[i] = chain[i/4][31 - 8*(i%4) -: 8];
			key_pad_block(OPAD_BYTE);
			blk_fill = 0;
			for (int i = 0; i < 20; i++)
				add_byte(inner[i]);
			pad_and_length(64'(BLOCK_BYTES + DIGEST_BYTES));
			mac_queue.push_back({chain[0], chain[1], chain[2], chain[3], chain[4]});
			for (int i = 0; i < 5; i++)
				chain[i] = SHA1_IV[159 - 32*i -: 32];
			blk_fill = 0;
			msg_count = '0;
			msg_open = 0;
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch on %s: got %h, expected %h (mac %0d)", what, got, want, macs_seen);
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Receiver: random stall on ready, check each accepted word against the oldest MAC.
	initial begin
		mac_t want;
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				if (mac_queue.size() == 0) begin
					report("unexpected mac", out_ch.digest_high, 64'h0);
				end else begin
					want = mac_queue.pop_front();
					if (out_ch.digest_high !== want.high)
						report("digest_high", out_ch.digest_high, want.high);
					if (out_ch.digest_mid !== want.mid)
						report("digest_mid", out_ch.digest_mid, want.mid);
					if (out_ch.digest_low !== want.low)
						report("digest_low", {32'h0, out_ch.digest_low}, {32'h0, want.low});
				end
				macs_seen++;
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Sends one word, with random idle cycles first, and waits for acceptance.
	task automatic send_word(input logic [7:0] v, input logic present, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data_byte <= v;
		in_ch.byte_present <= present;
		in_ch.end_of_message <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_word(v, present, last);
		words_sent++;
	endtask

	task automatic go_idle();
		in_ch.valid <= 0;
		@(posedge clk);
		while (mac_queue.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Drives one register write; the caller drops the write enable after the last one.
	task automatic write_key(input int idx, input logic [63:0] value);
		cfg_we <= 1;
		cfg_index <= 4'(idx);
		cfg_data <= value;
		@(posedge clk);
		key_regs[idx] = value;
	endtask

	// Random key of 0..64 bytes, zero past its length; sometimes all ones.
	task automatic load_random_key(input int mode);
		int len;
		logic [63:0] kw;
		len = (mode == 0) ? 0 : (mode == 1) ? 64 : $urandom_range(64);
		for (int i = 0; i < 8; i++) begin
			kw = {$urandom, $urandom};
			if (mode == 1)
				kw = '1;
			for (int j = 0; j < 8; j++)
				if (8*i + j >= len)
					kw[63 - 8*j -: 8] = 8'h00;
			write_key(i, kw);
		end
		cfg_we <= 0;
	endtask

	// Well-formed message with random content, a few of them with stray empty words.
	task automatic random_message(input int max_len);
		int len;
		len = $urandom_range(max_len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0)
				send_word(8'($urandom), 0, 0);
			send_word(8'($urandom), 1, (i == len - 1));
		end
		if (len == 0 || $urandom_range(9) == 0)
			send_word(8'($urandom), 1'($urandom_range(1)), 1);
	endtask

	row_t rows [$];

	initial begin
		row_t r;
		errors = 0;
		macs_seen = 0;
		words_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 0;
		in_ch.data_byte = '0;
		in_ch.byte_present = 0;
		in_ch.end_of_message = 0;
		for (int i = 0; i < 8; i++)
			key_regs[i] = '0;
		for (int i = 0; i < 5; i++)
			chain[i] = SHA1_IV[159 - 32*i -: 32];
		blk_fill = 0;
		msg_count = '0;
		msg_open = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed table. The empty message under the reset key has a known MAC.
		rows.push_back('{8'h00, 0, 1, 1,
			{64'hfbdb1d1b18aa6c08, 64'h324b7d64b71fb763, 32'h70690e1d}});
		rows.push_back('{8'hFF, 0, 0, 0, '0});
		rows.push_back('{8'h00, 1, 0, 0, '0});
		rows.push_back('{8'hFF, 1, 1, 0, '0});
		rows.push_back('{8'hA5, 1, 1, 0, '0});
		rows.push_back('{8'h5A, 0, 1, 0, '0});
		for (int i = 0; i < 64; i += 4)
			rows.push_back('{8'(i), 1, 0, 0, '0});
		rows.push_back('{8'h80, 1, 1, 0, '0});
		foreach (rows[i]) begin
			r = rows[i];
			send_word(r.data_byte, r.byte_present, r.end_of_message);
			if (r.check_known && mac_queue.size() != 0 &&
					mac_queue[$] !== r.known_mac)
				report("known empty-message mac", mac_queue[$].high, r.known_mac.high);
		end
		go_idle();

		// Full-length key, then a key change mid-message (outer pad sees the new key).
		load_random_key(1);
		send_word(8'h61, 1, 1);
		send_word(8'h00, 1, 0);
		go_idle();
		load_random_key(2);
		send_word(8'h00, 1, 1);
		go_idle();

		// Random phases over the idling mixes and several keys.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 73; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 73; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			load_random_key(phase == 0 ? 0 : 2);
			while (words_sent < 120 + (phase + 1) * 215)
				random_message(($urandom_range(7) == 0) ? 200 : 40);
			go_idle();
		end

		$display("covered %0d input words and %0d macs over the reset key and ten loaded keys",
			words_sent, macs_seen);
		$display("with sender idling and receiver stalling from 0 to 73 percent");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
hdl/hmac_pkg.sv
hdl/hmac_if.sv
hdl/hmac_queue.sv
hdl/hmac_sha1_core.sv
hdl/hmac_sha1_engine.sv
bench/tb_top.sv
